FILE: hdl/mfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion floodlight controller package
// Shared widths, mode codes, request codes and register indexes.
// ----------------------------------------------------------------------------
package mfc_pkg;

  // Field and register widths
  localparam int unsigned HoldW    = 8;
  localparam int unsigned ManualW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  // Lamp suppression window announced by the suppress pulse, in seconds
  localparam int unsigned SuppressSeconds = 10;

  // Operating modes (state codes)
  localparam logic [1:0] MODE_AUTO  = 2'd0;
  localparam logic [1:0] MODE_OPEN  = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  // Manual request codes
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_OPEN  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  // Day/night policy codes
  localparam logic [1:0] DN_AUTO   = 2'd0;
  localparam logic [1:0] DN_ALWAYS = 2'd1;
  localparam logic [1:0] DN_NEVER  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MOTION_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DAY_NIGHT     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIGHT_TICKS   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [HoldW-1:0]   HOLD_TICKS_RST  = 8'd10;
  localparam logic [ManualW-1:0] LIGHT_TICKS_RST = 16'd30;

endpackage

FILE: hdl/motion_floodlight_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion floodlight controller
// Security-light controller that advances one step per one-second tick.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one tick. The block takes one tick per
// clock cycle and loads its result into the output register on acceptance;
// the rate rests on the mode, lamp, hold and manual-countdown registers all
// updating together on each accepted tick. A new tick is taken whenever the
// output register is empty or being drained in the same cycle. After reset
// the mode is manual close with the lamp considered on, so the first tick
// switches the lamp off with a notification unless a manual open arrives.
// The suppress_motion pulse tells the camera to ignore motion for ten seconds.
module motion_floodlight_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [mfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mfc_pkg::CfgDataW-1:0] cfg_data_i,
  // Tick requests
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [0] motion, [1] night, [3:2] manual_request, [7:4] zero
  input  logic [mfc_pkg::InDataW-1:0] s_axis_tdata,
  // Tick results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] lamp_on, [1] force_day, [2] notify_valid, [3] notify_on,
  // [4] suppress_motion, [7:5] zero
  output logic [mfc_pkg::OutDataW-1:0] m_axis_tdata
);
  import mfc_pkg::*;

  // Configuration registers
  logic               motion_enable_q;
  logic [1:0]         day_night_q;
  logic [HoldW-1:0]   hold_ticks_q;
  logic [ManualW-1:0] light_ticks_q;

  // Controller state
  logic [1:0]         mode_q, mode_d;
  logic               lamp_q, lamp_d;
  logic               episode_q, episode_d;
  logic               reported_q, reported_d;
  logic [HoldW-1:0]   hold_q, hold_d;
  logic [ManualW-1:0] manual_q, manual_d;

  // Result of the current tick
  logic notify_valid, notify_on, suppress;

  // Output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // Input fields
  logic       motion, night;
  logic [1:0] req;
  logic       accept;

  assign motion = s_axis_tdata[0];
  assign night  = s_axis_tdata[1];
  assign req    = s_axis_tdata[3:2];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_enable_q <= 1'b0;
      day_night_q     <= DN_AUTO;
      hold_ticks_q    <= HOLD_TICKS_RST;
      light_ticks_q   <= LIGHT_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MOTION_ENABLE: motion_enable_q <= cfg_data_i[0];
        CFG_DAY_NIGHT:     day_night_q     <= cfg_data_i[1:0];
        CFG_HOLD_TICKS:    hold_ticks_q    <= cfg_data_i[HoldW-1:0];
        CFG_LIGHT_TICKS:   light_ticks_q   <= cfg_data_i[ManualW-1:0];
        default: ;
      endcase
    end
  end

  // One tick of the controller: a manual open or close request, else the mode step
  always_comb begin
    logic allowed;
    mode_d       = mode_q;
    lamp_d       = lamp_q;
    episode_d    = episode_q;
    reported_d   = reported_q;
    hold_d       = hold_q;
    manual_d     = manual_q;
    notify_valid = 1'b0;
    notify_on    = 1'b0;
    suppress     = 1'b0;
    allowed      = (day_night_q == DN_ALWAYS) || ((day_night_q == DN_AUTO) && night);

    case (req)
      REQ_OPEN: begin
        if (mode_q != MODE_OPEN) begin
          // Entering manual open; a lamp lit from close mode reports off first
          if ((mode_q == MODE_CLOSE) && lamp_q) begin
            notify_valid = 1'b1;
            suppress     = 1'b1;
          end
          if (!lamp_q) begin
            suppress = 1'b1;
          end
          lamp_d     = 1'b1;
          mode_d     = MODE_OPEN;
          episode_d  = 1'b0;
          reported_d = 1'b0;
          hold_d     = '0;
          manual_d   = light_ticks_q;
        end else if (manual_q != '0) begin
          manual_d = manual_q - 1'b1;
        end else begin
          // Open while open after the countdown ran out ends the open
          notify_valid = lamp_q;
          lamp_d       = 1'b0;
          suppress     = 1'b1;
          mode_d       = MODE_AUTO;
        end
      end
      REQ_CLOSE: begin
        if (mode_q == MODE_OPEN) begin
          suppress = 1'b1;
        end else if (lamp_q) begin
          notify_valid = 1'b1;
          suppress     = 1'b1;
        end
        lamp_d     = 1'b0;
        episode_d  = 1'b0;
        reported_d = 1'b0;
        hold_d     = '0;
        mode_d     = MODE_AUTO;
      end
      default: begin
        if (mode_q == MODE_OPEN) begin
          // Manual countdown
          if (manual_q != '0) begin
            manual_d = manual_q - 1'b1;
          end else begin
            notify_valid = 1'b1;
            lamp_d       = 1'b0;
            suppress     = 1'b1;
            mode_d       = MODE_AUTO;
          end
        end else if (mode_q == MODE_AUTO) begin
          if (!motion_enable_q) begin
            // Motion lighting disabled: switch off and drop the episode
            if (lamp_q) begin
              notify_valid = 1'b1;
              suppress     = 1'b1;
            end
            lamp_d     = 1'b0;
            episode_d  = 1'b0;
            reported_d = 1'b0;
            hold_d     = '0;
          end else begin
            // Hold window: motion reloads, quiet ticks count down
            if (motion) begin
              episode_d = 1'b1;
              hold_d    = hold_ticks_q;
            end else if (hold_q != '0) begin
              hold_d = hold_q - 1'b1;
            end else begin
              episode_d = 1'b0;
            end
            if (episode_d && !reported_q) begin
              if (allowed) begin
                reported_d   = 1'b1;
                lamp_d       = 1'b1;
                notify_valid = 1'b1;
                notify_on    = 1'b1;
                suppress     = 1'b1;
              end
            end else if (!episode_d && reported_q) begin
              if (lamp_q) begin
                notify_valid = 1'b1;
                suppress     = 1'b1;
              end
              lamp_d     = 1'b0;
              episode_d  = 1'b0;
              reported_d = 1'b0;
              hold_d     = '0;
            end
          end
        end else begin
          // Close mode: switch off and fall back to auto
          if (lamp_q) begin
            notify_valid = 1'b1;
            suppress     = 1'b1;
          end
          lamp_d     = 1'b0;
          episode_d  = 1'b0;
          reported_d = 1'b0;
          hold_d     = '0;
          mode_d     = MODE_AUTO;
        end
      end
    endcase
  end

  // State update on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_CLOSE;
      lamp_q     <= 1'b1;
      episode_q  <= 1'b0;
      reported_q <= 1'b0;
      hold_q     <= '0;
      manual_q   <= '0;
    end else if (accept) begin
      mode_q     <= mode_d;
      lamp_q     <= lamp_d;
      episode_q  <= episode_d;
      reported_q <= reported_d;
      hold_q     <= hold_d;
      manual_q   <= manual_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {3'b000, suppress, notify_on, notify_valid, lamp_d, lamp_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: hdl/mfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion floodlight controller checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mfc_assertions (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mfc_pkg::OutDataW-1:0] m_axis_tdata
);
  import mfc_pkg::*;

  // The camera day profile follows the lamp in every result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1] == m_axis_tdata[0]))
    else $error("force_day differs from lamp_on");

  // Every notification comes with a suppress pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[4])
    else $error("notification without suppress pulse");

  // A light-started notification is valid and leaves the lamp on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2] && m_axis_tdata[0]))
    else $error("notify_on without valid notification and lit lamp");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind motion_floodlight_controller mfc_assertions u_mfc_assertions (.*);

FILE: bench/mfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion floodlight controller checker
// Watches the configuration port and both streams. It predicts one result
// per accepted tick request and compares each returned result, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mfc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mfc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // [0] motion, [1] night, [3:2] manual_request, [7:4] zero
  input  logic [mfc_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] lamp_on, [1] force_day, [2] notify_valid, [3] notify_on,
  // [4] suppress_motion, [7:5] zero
  input  logic [mfc_pkg::OutDataW-1:0]  m_axis_tdata,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  import mfc_pkg::*;

  typedef struct packed {
    logic lamp_on;
    logic force_day;
    logic notify_valid;
    logic notify_on;
    logic suppress_motion;
  } tick_result_t;

  // Shadow copy of the configuration registers.
  logic               motion_en;
  logic [1:0]         day_night;
  logic [HoldW-1:0]   hold_ticks;
  logic [ManualW-1:0] light_ticks;

  // Shadow copy of the controller state.
  logic [1:0]         op_mode;
  logic               lamp;
  logic               episode;
  logic               reported;
  logic [HoldW-1:0]   hold_cnt;
  logic [ManualW-1:0] manual_cnt;

  // Events raised while one tick is evaluated.
  logic               ev_valid;
  logic               ev_on;
  logic               ev_pulse;

  tick_result_t       lamp_reports_q[$];
  int                 fail_count = 0;

  // Switch a lit lamp off and announce the end of the light.
  function automatic void lamp_off();
    if (lamp) begin
      lamp     = 1'b0;
      ev_valid = 1'b1;
      ev_on    = 1'b0;
      ev_pulse = 1'b1;
    end
  endfunction

  function automatic void drop_episode();
    episode  = 1'b0;
    reported = 1'b0;
    hold_cnt = '0;
  endfunction

  // One step of motion-driven operation in auto mode.
  function automatic void auto_tick(logic motion, logic night);
    logic may_light;
    if (!motion_en) begin
      lamp_off();
      drop_episode();
      return;
    end
    if (motion) begin
      episode  = 1'b1;
      hold_cnt = hold_ticks;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1'b1;
    end else begin
      episode = 1'b0;
    end
    if (episode && !reported) begin
      // Codes above the never setting behave as never.
      may_light = (day_night == DN_ALWAYS) || (day_night == DN_AUTO && night);
      if (may_light) begin
        reported = 1'b1;
        lamp     = 1'b1;
        ev_valid = 1'b1;
        ev_on    = 1'b1;
        ev_pulse = 1'b1;
      end
    end else if (!episode && reported) begin
      lamp_off();
      drop_episode();
    end
  endfunction

  // Advance the shadow state by one tick and return the expected result.
  function automatic tick_result_t predict_tick(logic motion, logic night, logic [1:0] req);
    tick_result_t res;
    ev_valid = 1'b0;
    ev_on    = 1'b0;
    ev_pulse = 1'b0;
    if (req == REQ_OPEN) begin
      if (op_mode != MODE_OPEN) begin
        if (op_mode == MODE_CLOSE) lamp_off();
        op_mode = MODE_OPEN;
        drop_episode();
        if (!lamp) begin
          lamp     = 1'b1;
          ev_pulse = 1'b1;
        end
        manual_cnt = light_ticks;
      end else if (manual_cnt != 0) begin
        // A repeated open only keeps counting down.
        manual_cnt = manual_cnt - 1'b1;
      end else begin
        lamp_off();
        lamp     = 1'b0;
        ev_pulse = 1'b1;
        op_mode  = MODE_AUTO;
      end
    end else if (req == REQ_CLOSE) begin
      if (op_mode == MODE_OPEN) begin
        lamp     = 1'b0;
        ev_pulse = 1'b1;
      end else begin
        lamp_off();
      end
      drop_episode();
      op_mode = MODE_AUTO;
    end else if (op_mode == MODE_OPEN) begin
      if (manual_cnt != 0) begin
        manual_cnt = manual_cnt - 1'b1;
      end else begin
        ev_valid = 1'b1;
        ev_on    = 1'b0;
        lamp     = 1'b0;
        ev_pulse = 1'b1;
        op_mode  = MODE_AUTO;
      end
    end else if (op_mode == MODE_AUTO) begin
      auto_tick(motion, night);
    end else begin
      lamp_off();
      drop_episode();
      op_mode = MODE_AUTO;
    end
    res.lamp_on         = lamp;
    res.force_day       = lamp;
    res.notify_valid    = ev_valid;
    res.notify_on       = ev_on;
    res.suppress_motion = ev_pulse;
    return res;
  endfunction

  task automatic compare_bit(string name, logic want, logic seen);
    if (want !== seen) begin
      fail_count++;
      $error("mfc_checker: %s expected %0d got %0d", name, want, seen);
    end
  endtask

  // Track configuration, predict on each tick request, check each result.
  always @(posedge clk_i or negedge rst_ni) begin : track
    tick_result_t want;
    if (!rst_ni) begin
      motion_en   = 1'b0;
      day_night   = DN_AUTO;
      hold_ticks  = HOLD_TICKS_RST;
      light_ticks = LIGHT_TICKS_RST;
      op_mode     = MODE_CLOSE;
      lamp        = 1'b1;
      drop_episode();
      manual_cnt  = '0;
      lamp_reports_q.delete();
      outstanding_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lamp_reports_q.size() == 0) begin
          fail_count++;
          $error("mfc_checker: result 0x%02h arrived with no tick pending", m_axis_tdata);
        end else begin
          want = lamp_reports_q.pop_front();
          compare_bit("lamp_on", want.lamp_on, m_axis_tdata[0]);
          compare_bit("force_day", want.force_day, m_axis_tdata[1]);
          compare_bit("notify_valid", want.notify_valid, m_axis_tdata[2]);
          compare_bit("notify_on", want.notify_on, m_axis_tdata[3]);
          compare_bit("suppress_motion", want.suppress_motion, m_axis_tdata[4]);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MOTION_ENABLE: motion_en   = cfg_data_i[0];
          CFG_DAY_NIGHT:     day_night   = cfg_data_i[1:0];
          CFG_HOLD_TICKS:    hold_ticks  = cfg_data_i[HoldW-1:0];
          CFG_LIGHT_TICKS:   light_ticks = cfg_data_i[ManualW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lamp_reports_q.push_back(predict_tick(s_axis_tdata[0], s_axis_tdata[1],
                                              s_axis_tdata[3:2]));
      end
      outstanding_o <= lamp_reports_q.size();
    end
    fail_count_o <= fail_count;
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion floodlight controller testbench
// Drives a directed tick sequence through the special cases, then random
// phases of motion bursts, night changes and manual requests under several
// settings and handshake pressures; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import mfc_pkg::*;

  localparam int         CycleLimit = 400000;
  localparam int         PhaseTicks = 225;
  localparam logic [1:0] ReqUnused  = 2'd3;
  localparam logic [1:0] DnUnused   = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i     = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [0] motion, [1] night, [3:2] manual_request, [7:4] zero
  logic [InDataW-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] lamp_on, [1] force_day, [2] notify_valid, [3] notify_on,
  // [4] suppress_motion, [7:5] zero
  logic [OutDataW-1:0]   m_axis_tdata;

  int                    fail_count;
  int                    outstanding;
  int                    src_idle_pct  = 0;
  int                    snk_stall_pct = 0;
  int                    cycle_cnt     = 0;

  always #6 clk_i = ~clk_i;

  motion_floodlight_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mfc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Result side back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog on a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Offer one tick request after a random idle gap. Valid stays high on
  // return so that back-to-back requests never toggle it within one step.
  task automatic send_tick(logic motion, logic night, logic [1:0] req);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, req, night, motion};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering ticks and wait for every predicted result to come back.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write all four registers on consecutive cycles; the block is idle here.
  task automatic apply_setting(logic en, logic [1:0] dn, logic [HoldW-1:0] hold,
                               logic [ManualW-1:0] light);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MOTION_ENABLE;
    cfg_data_i <= CfgDataW'(en);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DAY_NIGHT;
    cfg_data_i <= CfgDataW'(dn);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HOLD_TICKS;
    cfg_data_i <= CfgDataW'(hold);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LIGHT_TICKS;
    cfg_data_i <= light;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random phase: night changes slowly, motion comes in bursts, manual
  // requests are sparse. Halfway through the sender waits for a full drain.
  task automatic run_phase(logic en, logic [1:0] dn, logic [HoldW-1:0] hold,
                           logic [ManualW-1:0] light, int src_pct, int snk_pct);
    logic       night_lvl;
    logic       burst;
    logic       motion;
    logic [1:0] req;
    int         roll;
    night_lvl = 1'($urandom_range(1));
    burst     = 1'b0;
    wait_results_drained();
    apply_setting(en, dn, hold, light);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < PhaseTicks; i++) begin
      if (i == PhaseTicks / 2) wait_results_drained();
      if ($urandom_range(15) == 0) night_lvl = ~night_lvl;
      if ($urandom_range(7) == 0) burst = ~burst;
      motion = burst ? ($urandom_range(3) != 0) : ($urandom_range(9) == 0);
      roll   = $urandom_range(99);
      if (roll < 88)      req = REQ_NONE;
      else if (roll < 94) req = REQ_OPEN;
      else if (roll < 97) req = REQ_CLOSE;
      else                req = ReqUnused;
      send_tick(motion, night_lvl, req);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Right after reset the block sits in manual close with the lamp on.
    send_tick(1'b0, 1'b0, REQ_NONE);
    wait_results_drained();
    apply_setting(1'b1, DN_AUTO, 8'd2, 16'd1);

    // Episode seen by day stays pending, then lights once night comes.
    send_tick(1'b1, 1'b0, REQ_NONE);
    send_tick(1'b0, 1'b1, REQ_NONE);
    send_tick(1'b0, 1'b1, REQ_NONE);
    send_tick(1'b0, 1'b1, REQ_NONE);
    // New episode, then manual opens on top of it and a timeout.
    send_tick(1'b1, 1'b1, REQ_NONE);
    send_tick(1'b0, 1'b1, REQ_OPEN);
    send_tick(1'b0, 1'b1, REQ_OPEN);
    send_tick(1'b1, 1'b1, ReqUnused);
    // Open from a dark lamp, then close during the open.
    send_tick(1'b0, 1'b0, REQ_OPEN);
    send_tick(1'b1, 1'b1, REQ_CLOSE);
    // Close while an auto episode keeps the lamp lit.
    send_tick(1'b1, 1'b1, REQ_NONE);
    send_tick(1'b1, 1'b1, REQ_CLOSE);
    // An episode by day that ends without ever lighting.
    send_tick(1'b1, 1'b0, REQ_NONE);
    send_tick(1'b0, 1'b0, REQ_NONE);
    send_tick(1'b0, 1'b0, REQ_NONE);
    send_tick(1'b0, 1'b0, REQ_NONE);

    // Unused day/night code, zero hold and zero open duration.
    wait_results_drained();
    apply_setting(1'b1, DnUnused, 8'd0, 16'd0);
    send_tick(1'b1, 1'b1, REQ_NONE);
    send_tick(1'b0, 1'b1, REQ_OPEN);
    send_tick(1'b0, 1'b1, REQ_NONE);

    // Always-light policy, then motion disabled while the lamp is lit.
    wait_results_drained();
    apply_setting(1'b1, DN_ALWAYS, 8'd0, 16'd0);
    send_tick(1'b1, 1'b0, REQ_NONE);
    wait_results_drained();
    apply_setting(1'b0, DN_ALWAYS, 8'hFF, 16'hFFFF);
    send_tick(1'b1, 1'b1, REQ_NONE);
    send_tick(1'b1, 1'b1, REQ_OPEN);
    send_tick(1'b0, 1'b0, REQ_CLOSE);

    // Random phases across settings and handshake pressures.
    run_phase(1'b1, DN_AUTO,   8'd3,   16'd4,     0,  0);
    run_phase(1'b1, DN_ALWAYS, 8'd0,   16'd0,     76, 0);
    run_phase(1'b1, DN_NEVER,  8'hFF,  16'hFFFF,  0,  76);
    run_phase(1'b0, DN_AUTO,   8'd10,  16'd30,    11, 11);
    run_phase(1'b1, DnUnused,  8'd1,   16'd2,     0,  0);
    run_phase(1'b1, DN_AUTO,   8'd5,   16'd7,     76, 0);
    run_phase(1'b1, DN_ALWAYS, 8'd2,   16'd1,     0,  76);
    run_phase(1'b1, DN_AUTO,   8'd0,   16'd3,     11, 11);

    wait_results_drained();
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mfc_pkg.sv
hdl/motion_floodlight_controller.sv
hdl/mfc_checker.sv
bench/mfc_checker.sv
bench/tb_top.sv
